// ===== rtl/assert_macros.svh =====
// Assertion helpers for the console writer. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCCW_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define TCCW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define TCCW_ASSERT(lbl, cond, msg)
`define TCCW_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/tccw_pkg.sv =====
`default_nettype none
package tccw_pkg;

  // operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // character codes
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  localparam logic [7:0] ATTR_RESET = 8'h0F;
  localparam int         TAB_STOP   = 8;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_location;
    logic [15:0] cell_value;
    logic        scrolled;
  } out_item_t;

  typedef enum logic [2:0] {
    K_NOP, K_BS, K_TAB, K_CR, K_LF, K_PRINT, K_CLEAR, K_READ
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  ch;
    logic [10:0] cell_index;
    logic        addr_ok;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  function automatic logic [15:0] blank_cell(input logic [7:0] attr);
    return {attr, CH_SPACE};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/text_console_char_writer_top.sv =====
// A put's result goes through the command queue into the output register; a read's result
//   also goes through the registered store read port. The back takes no new command while its
//   output register stalls or a clear or scroll sweep runs (one store write per cycle).
// Reset: synchronous rst_n; afterward the store is swept to blank 0x0F20, one cell per cycle,
//   over all ROWS*COLUMNS cells while in_stall stays high.
`default_nettype none
`include "assert_macros.svh"
module text_console_char_writer_top import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic      clk,
  input  logic      rst_n,
  // input transactions
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  // result transactions
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  // attribute register write
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [7:0] cfg_data
);

  // Attribute register; writes are always taken.
  logic [7:0] attr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attr_r <= cfg_data;
    end
  end

  back_status_t bstat;
  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_empty;
  cmd_t         push_cmd;
  cmd_t         pop_cmd;

  // Front: accepts transactions and decodes them into commands.
  tccw_front #(
    .CELLS (ROWS * COLUMNS)
  ) u_front (
    .in_item  (in_item),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .q_full   (q_full),
    .bstat    (bstat),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // Short command queue so the front keeps taking work while the back is busy.
  tccw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  // Back: cursor, screen store, scroll/clear sweeps, and output register.
  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .attr      (attr_r),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .bstat     (bstat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // No transaction may enter while the reset sweep still owns the store.
  `TCCW_ASSERT_IMP(a_init_blocks_input, bstat.init_busy, in_stall, "input taken during reset sweep")
  // Reported column always lies on the screen.
  `TCCW_ASSERT_IMP(a_col_range, out_valid, 32'(out_item.cursor_col) < 32'(COLUMNS), "cursor column out of range")
  // A scroll always leaves the cursor on the last row.
  `TCCW_ASSERT_IMP(a_scroll_row, out_valid && out_item.scrolled, out_item.cursor_row == 5'(ROWS - 1), "scroll left cursor off last row")
  // The back never pops an empty queue.
  `TCCW_ASSERT(a_no_pop_empty, !(q_pop && q_empty), "pop from empty queue")

endmodule
`default_nettype wire

// ===== rtl/tccw_front.sv =====
`default_nettype none
module tccw_front import tccw_pkg::*; #(
  parameter int CELLS = 2000
) (
  input  in_item_t     in_item,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         q_full,
  input  back_status_t bstat,
  output logic         q_push,
  output cmd_t         q_cmd
);

  assign in_stall = q_full | bstat.init_busy;
  assign q_push   = in_valid & ~in_stall;

  always_comb begin
    q_cmd.ch         = in_item.char_code;
    q_cmd.cell_index = in_item.cell_index;
    q_cmd.addr_ok    = (32'(in_item.cell_index) < 32'(CELLS));
    case (in_item.operation)
      OP_PUT: begin
        case (in_item.char_code)
          CH_BS:   q_cmd.kind = K_BS;
          CH_TAB:  q_cmd.kind = K_TAB;
          CH_LF:   q_cmd.kind = K_LF;
          CH_CR:   q_cmd.kind = K_CR;
          default: q_cmd.kind = (in_item.char_code inside {[CH_SPACE:CH_PRINT_HI]}) ?
                                K_PRINT : K_NOP;
        endcase
      end
      OP_CLEAR: q_cmd.kind = K_CLEAR;
      OP_READ:  q_cmd.kind = K_READ;
      default:  q_cmd.kind = K_NOP;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tccw_queue.sv =====
`default_nettype none
module tccw_queue import tccw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  // two-entry FIFO
  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign pop_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tccw_back.sv =====
`default_nettype none
module tccw_back import tccw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [7:0]   attr,
  input  logic         q_empty,
  input  cmd_t         q_cmd,
  output logic         q_pop,
  output back_status_t bstat,
  output logic         out_valid,
  input  logic         out_stall,
  output out_item_t    out_item
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int AW     = $clog2(CELLS);
  localparam int CW     = $clog2(COLUMNS);
  localparam int RW     = $clog2(ROWS);
  localparam int COPY_N = (ROWS - 1) * COLUMNS;

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COPY_END  = AW'(COPY_N);
  localparam logic [CW:0]   COL_LIMIT = (CW+1)'(COLUMNS);
  localparam logic [RW:0]   ROW_LIMIT = (RW+1)'(ROWS);
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW:0]   TAB_STEP  = (CW+1)'(TAB_STOP);
  localparam logic [CW:0]   TAB_MASK  = ~((CW+1)'(TAB_STOP - 1));

  typedef enum logic [2:0] {ST_INIT, ST_RUN, ST_COPY, ST_FILL, ST_DONE} state_t;

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [CW-1:0] c);
    return AW'(AW'(r) * AW'(COLUMNS)) + AW'(c);
  endfunction

  // screen store
  logic [15:0] mem [CELLS];
  logic [15:0] rdata_r;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic        wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  state_t        state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          cp_wr_v_r, cp_wr_v_nxt;
  logic [AW-1:0] cp_wr_addr_r;
  logic [15:0]   fill_val_r, fill_val_nxt;
  logic          pend_scroll_r, pend_scroll_nxt;
  logic          pend_read_r, pend_read_nxt;
  logic          pend_ok_r, pend_ok_nxt;
  logic          out_valid_r;
  out_item_t     out_item_r;

  logic          out_free;
  logic          load_out;
  logic          res_scroll;
  logic [15:0]   res_value;
  logic [AW-1:0] res_loc;

  // cursor update for a put
  logic [CW:0]   pc_col;
  logic [RW:0]   pc_row;
  logic          put_scroll;

  always_comb begin
    pc_col = {1'b0, col_r};
    pc_row = {1'b0, row_r};
    case (q_cmd.kind)
      K_BS: begin
        if (col_r != '0) begin
          pc_col = pc_col - (CW+1)'(1);
        end
      end
      K_TAB:   pc_col = (pc_col + TAB_STEP) & TAB_MASK;
      K_CR:    pc_col = '0;
      K_LF: begin
        pc_col = '0;
        pc_row = pc_row + (RW+1)'(1);
      end
      K_PRINT: pc_col = pc_col + (CW+1)'(1);
      default: ;
    endcase
    if (pc_col >= COL_LIMIT) begin
      pc_col = '0;
      pc_row = pc_row + (RW+1)'(1);
    end
    put_scroll = (pc_row >= ROW_LIMIT);
    if (put_scroll) begin
      pc_row = {1'b0, ROW_LAST};
    end
  end

  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt       = state_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    ptr_nxt         = ptr_r;
    cp_wr_v_nxt     = 1'b0;
    fill_val_nxt    = fill_val_r;
    pend_scroll_nxt = pend_scroll_r;
    pend_read_nxt   = pend_read_r;
    pend_ok_nxt     = pend_ok_r;
    q_pop           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = ptr_r + AW'(COLUMNS);
    wr_en           = 1'b0;
    wr_addr         = ptr_r;
    wr_data         = fill_val_r;
    load_out        = 1'b0;
    res_scroll      = 1'b0;
    res_value       = '0;
    case (state_r)
      ST_INIT: begin
        wr_en   = 1'b1;
        wr_data = blank_cell(ATTR_RESET);
        if (ptr_r == LAST_CELL) begin
          ptr_nxt   = '0;
          state_nxt = ST_RUN;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      ST_RUN: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            K_CLEAR: begin
              col_nxt         = '0;
              row_nxt         = '0;
              ptr_nxt         = '0;
              fill_val_nxt    = blank_cell(attr);
              pend_scroll_nxt = 1'b0;
              pend_read_nxt   = 1'b0;
              state_nxt       = ST_FILL;
            end
            K_READ: begin
              rd_en           = 1'b1;
              rd_addr         = AW'(q_cmd.cell_index);
              pend_read_nxt   = 1'b1;
              pend_ok_nxt     = q_cmd.addr_ok;
              pend_scroll_nxt = 1'b0;
              state_nxt       = ST_DONE;
            end
            default: begin
              col_nxt = CW'(pc_col);
              row_nxt = RW'(pc_row);
              if (q_cmd.kind == K_PRINT) begin
                wr_en   = 1'b1;
                wr_addr = cell_addr(row_r, col_r);
                wr_data = {attr, q_cmd.ch};
              end
              if (put_scroll) begin
                ptr_nxt         = '0;
                fill_val_nxt    = blank_cell(attr);
                pend_scroll_nxt = 1'b1;
                pend_read_nxt   = 1'b0;
                state_nxt       = ST_COPY;
              end else begin
                load_out = 1'b1;
              end
            end
          endcase
        end
      end
      ST_COPY: begin
        // read one row ahead, write back in the following cycle
        if (cp_wr_v_r) begin
          wr_en   = 1'b1;
          wr_addr = cp_wr_addr_r;
          wr_data = rdata_r;
        end
        if (ptr_r != COPY_END) begin
          rd_en       = 1'b1;
          cp_wr_v_nxt = 1'b1;
          ptr_nxt     = ptr_r + AW'(1);
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        wr_en = 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt = ptr_r + AW'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          res_scroll = pend_scroll_r;
          res_value  = (pend_read_r && pend_ok_r) ? rdata_r : '0;
          state_nxt  = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  assign res_loc = cell_addr(row_nxt, col_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_INIT;
      col_r         <= '0;
      row_r         <= '0;
      ptr_r         <= '0;
      cp_wr_v_r     <= 1'b0;
      pend_scroll_r <= 1'b0;
      pend_read_r   <= 1'b0;
      pend_ok_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      ptr_r         <= ptr_nxt;
      cp_wr_v_r     <= cp_wr_v_nxt;
      pend_scroll_r <= pend_scroll_nxt;
      pend_read_r   <= pend_read_nxt;
      pend_ok_r     <= pend_ok_nxt;
      out_valid_r   <= load_out | (out_valid_r & out_stall);
    end
    cp_wr_addr_r <= ptr_r;
    fill_val_r   <= fill_val_nxt;
    if (load_out) begin
      out_item_r.cursor_col      <= 7'(col_nxt);
      out_item_r.cursor_row      <= 5'(row_nxt);
      out_item_r.cursor_location <= 11'(res_loc);
      out_item_r.cell_value      <= res_value;
      out_item_r.scrolled        <= res_scroll;
    end
  end

  assign bstat.init_busy = (state_r == ST_INIT);
  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;

endmodule
`default_nettype wire

// ===== tb/text_console_char_writer_top_tb.sv =====
`default_nettype none
module text_console_char_writer_top_tb import tccw_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  // Operation 3 has no meaning; the block must still answer with the cursor.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // First byte of the upper half (negative as signed char), ignored by a put.
  localparam logic [7:0] CH_HIGH_HALF = 8'h80;

  // Random part: about 1700 transactions in total, split over attribute phases.
  localparam int PHASE_ITEMS = 336;
  // Receiver hold-off and the stretch without any idling, keyed to the count
  // of accepted input transactions.
  localparam int HOLD_AT      = 500;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_FROM   = 1000;
  localparam int QUIET_TO     = 1300;
  // Drain time after the last result.
  localparam int TAIL_CYCLES  = 40;

  // Screen model: cells, cursor and attribute register, plus the queue of
  // results still owed by the block.
  class console_scoreboard;
    logic [15:0] screen [CELLS];
    int unsigned col;
    int unsigned row;
    logic [7:0]  attr;
    out_item_t   expected_q[$];
    int          errors;

    function new();
      attr   = ATTR_RESET;
      col    = 0;
      row    = 0;
      errors = 0;
      blank_all();
    endfunction

    function logic [15:0] blank();
      return {attr, CH_SPACE};
    endfunction

    function void blank_all();
      foreach (screen[i]) screen[i] = blank();
    endfunction

    function void set_attr(logic [7:0] a);
      attr = a;
    endfunction

    function int unsigned cursor_cell();
      return row * COLS + col;
    endfunction

    // Apply one accepted transaction and queue the result it must produce.
    function void note_input(in_item_t it);
      out_item_t e;
      int        i;
      e = '0;
      case (it.operation)
        OP_PUT: begin
          if (it.char_code == CH_BS && col != 0) begin
            col--;
          end else if (it.char_code == CH_TAB) begin
            col = (col + TAB_STOP) & ~(TAB_STOP - 1);
          end else if (it.char_code == CH_CR) begin
            col = 0;
          end else if (it.char_code == CH_LF) begin
            col = 0;
            row++;
          end else if (it.char_code >= CH_SPACE && it.char_code <= CH_PRINT_HI) begin
            screen[row * COLS + col] = {attr, it.char_code};
            col++;
          end
          if (col >= COLS) begin
            col = 0;
            row++;
          end
          if (row >= ROWS) begin
            for (i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
            for (i = CELLS - COLS; i < CELLS; i++) screen[i] = blank();
            row = ROWS - 1;
            e.scrolled = 1'b1;
          end
        end
        OP_CLEAR: begin
          blank_all();
          col = 0;
          row = 0;
        end
        OP_READ: begin
          if (it.cell_index < CELLS) e.cell_value = screen[it.cell_index];
        end
        default: ;
      endcase
      e.cursor_col      = 7'(col);
      e.cursor_row      = 5'(row);
      e.cursor_location = 11'(row * COLS + col);
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d (0x%0h) actual %0d (0x%0h)",
                 $time, name, exp_v, exp_v, act_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none actual 0x%0h",
                 $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("cursor_col", e.cursor_col, got.cursor_col);
      compare_field("cursor_row", e.cursor_row, got.cursor_row);
      compare_field("cursor_location", e.cursor_location, got.cursor_location);
      compare_field("cell_value", e.cell_value, got.cell_value);
      compare_field("scrolled", e.scrolled, got.scrolled);
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_item   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data  = '0;

  console_scoreboard sb = new();

  // Shared between the sender and the receiver process.
  int items_sent = 0;
  bit quiet      = 1'b0;

  text_console_char_writer_top #(
    .COLUMNS(COLS),
    .ROWS   (ROWS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Safety net: even with every transaction scrolling the full screen and
  // every gap and stall at its longest, a correct run ends far sooner.
  initial begin
    #200ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: stalls about 9% of the time, not at all during the quiet
  // stretch, and once holds off for a long run of cycles while the sender keeps
  // offering, so that the block backs up and raises in_stall.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && items_sent >= HOLD_AT) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !quiet && ($urandom_range(0, 99) < 9);
    end
  end

  // Result monitor: a transaction completes at an edge with out_valid high and
  // out_stall low; values sampled here are the ones from before the edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  function automatic in_item_t make_item(logic [1:0] op, logic [7:0] ch, logic [10:0] idx);
    in_item_t it;
    it.operation  = op;
    it.char_code  = ch;
    it.cell_index = idx;
    return it;
  endfunction

  // Offer one transaction, with random idle cycles in front of it. in_valid
  // stays high from one transaction into the next unless an idle cycle falls
  // in between, so it never gets two assignments in one time step.
  task automatic send_item(in_item_t it);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(it);
    items_sent++;
    quiet = (items_sent >= QUIET_FROM && items_sent < QUIET_TO);
  endtask

  task automatic put(logic [7:0] ch);
    send_item(make_item(OP_PUT, ch, 11'($urandom_range(0, 2047))));
  endtask

  task automatic read_cell(logic [10:0] idx);
    send_item(make_item(OP_READ, 8'($urandom_range(0, 255)), idx));
  endtask

  // Let the block run dry: every result back and the input side open again
  // (a clear or scroll sweep may still hold in_stall).
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_attr(logic [7:0] a);
    settle();
    cfg_data  <= a;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_attr(a);
    cfg_valid <= 1'b0;
  endtask

  // Mostly printable text, with a good share of cursor controls and a few
  // bytes that must be ignored.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 58) return 8'($urandom_range(CH_SPACE, CH_PRINT_HI));
    if (r < 70) return CH_LF;
    if (r < 78) return CH_TAB;
    if (r < 84) return CH_CR;
    if (r < 90) return CH_BS;
    if (r < 95) return 8'($urandom_range(0, CH_SPACE - 1));
    return 8'($urandom_range(CH_HIGH_HALF, 8'hFF));
  endfunction

  // One random transaction of any operation. Half the reads look just behind
  // the cursor, where text was most likely written.
  task automatic random_single();
    int          r;
    int unsigned loc;
    int unsigned back;
    r = $urandom_range(0, 99);
    if (r < 78) begin
      put(pick_char());
    end else if (r < 92) begin
      if ($urandom_range(0, 1)) begin
        loc  = sb.cursor_cell();
        back = $urandom_range(1, 8);
        read_cell(11'((loc >= back) ? loc - back : 0));
      end else begin
        read_cell(11'($urandom_range(0, 2047)));
      end
    end else if (r < 95) begin
      send_item(make_item(OP_UNUSED, 8'($urandom_range(0, 255)),
                          11'($urandom_range(0, 2047))));
    end else begin
      send_item(make_item(OP_CLEAR, 8'($urandom_range(0, 255)),
                          11'($urandom_range(0, 2047))));
    end
  endtask

  // Random traffic shaped as console output: lines of text, runs of line
  // feeds and tabs that drive wrap and scroll, mixed with single transactions.
  task automatic random_phase(int count);
    int start;
    int kind;
    int n;
    start = items_sent;
    while (items_sent - start < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        random_single();
      end else if (kind < 85) begin
        n = $urandom_range(10, 90);
        repeat (n) put(8'($urandom_range(CH_SPACE, CH_PRINT_HI)));
        put($urandom_range(0, 3) ? CH_LF : CH_CR);
      end else if (kind < 95) begin
        n = $urandom_range(1, 10);
        repeat (n) put(CH_LF);
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) put(CH_TAB);
      end
    end
  endtask

  // Main sequence: reset, directed checks at the reset attribute, then random
  // phases, each opened by an attribute write while the block is idle.
  initial begin
    logic [7:0] attrs [5];
    attrs[0] = 8'h00;
    attrs[1] = 8'hFF;
    attrs[2] = 8'hA5;
    attrs[3] = 8'($urandom_range(0, 255));
    attrs[4] = 8'h5A;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Screen after reset: first and last cells blank, past-the-end reads zero.
    read_cell(11'd0);
    read_cell(11'(CELLS - 1));
    read_cell(11'd2047);
    // Printable extremes, then ignored control and upper-half bytes.
    put(8'h41);
    put(CH_SPACE);
    put(CH_PRINT_HI);
    put(8'h1F);
    put(CH_HIGH_HALF);
    put(8'hFF);
    put(8'h00);
    // Cursor moves: backspace, return, backspace at column 0, tab, line feed.
    put(CH_BS);
    put(CH_CR);
    put(CH_BS);
    put(CH_TAB);
    put(8'h42);
    put(CH_LF);
    send_item(make_item(OP_UNUSED, 8'h41, 11'd0));
    read_cell(11'd0);
    read_cell(11'd1);
    read_cell(11'd2);
    read_cell(11'd8);
    // Clear homes the cursor and blanks the store.
    send_item(make_item(OP_CLEAR, 8'h00, 11'd0));
    read_cell(11'd8);
    read_cell(11'(CELLS));

    foreach (attrs[p]) begin
      write_attr(attrs[p]);
      random_phase(PHASE_ITEMS);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/tccw_pkg.sv
rtl/tccw_front.sv
rtl/tccw_queue.sv
rtl/tccw_back.sv
rtl/text_console_char_writer_top.sv
tb/text_console_char_writer_top_tb.sv
